### design/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

    // field widths
    localparam int RX_W       = 8;
    localparam int LEN_W      = 10;
    localparam int CMD_W      = 16;
    localparam int SEQ_W      = 8;
    localparam int CRC8_W     = 8;
    localparam int CRC16_W    = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // frame size limit, and the allowance subtracted from it to give the payload length cap
    localparam int FRAME_MAX_BYTES_DEF = 128;
    localparam int FRAME_OVERHEAD      = 10;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC8_POLY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC8_INIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC16_POLY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC16_INIT  = 3'd5;

    // configuration reset values
    localparam logic [RX_W-1:0]    RST_START_BYTE = 8'hA5;
    localparam logic [LEN_W-1:0]   RST_MAX_LEN    = 10'd118;
    localparam logic [CRC8_W-1:0]  RST_CRC8_POLY  = 8'h8C;
    localparam logic [CRC8_W-1:0]  RST_CRC8_INIT  = 8'hFF;
    localparam logic [CRC16_W-1:0] RST_CRC16_POLY = 16'h8408;
    localparam logic [CRC16_W-1:0] RST_CRC16_INIT = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_LEN_LO = 3'd1,
        ST_LEN_HI = 3'd2,
        ST_SEQ    = 3'd3,
        ST_HCRC   = 3'd4,
        ST_CMD_LO = 3'd5,
        ST_CMD_HI = 3'd6,
        ST_BODY   = 3'd7
    } t_parse_step;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } t_result_kind;

    typedef struct packed {
        logic [RX_W-1:0]    start_byte;
        logic [LEN_W-1:0]   max_len;
        logic [CRC8_W-1:0]  crc8_poly;
        logic [CRC8_W-1:0]  crc8_init;
        logic [CRC16_W-1:0] crc16_poly;
        logic [CRC16_W-1:0] crc16_init;
    } t_cfg;

    typedef struct packed {
        t_result_kind      kind;
        logic [RX_W-1:0]   payload_byte;
        logic [CMD_W-1:0]  command_id;
        logic [LEN_W-1:0]  payload_length;
        logic [SEQ_W-1:0]  sequence_number;
        logic              link;
    } t_result;

endpackage

`default_nettype wire

### design/cfp_rx_if.sv
`default_nettype none

interface cfp_rx_if;
    logic                        valid;
    logic                        ready;
    logic [cfp_pkg::RX_W-1:0]    rx_byte;
    logic                        source_link;

    modport source (output valid, output rx_byte, output source_link, input ready);
    modport sink   (input valid, input rx_byte, input source_link, output ready);
endinterface

`default_nettype wire

### design/cfp_res_if.sv
`default_nettype none

interface cfp_res_if;
    logic                         valid;
    logic                         ready;
    logic [cfp_pkg::KIND_W-1:0]   result_kind;
    logic [cfp_pkg::RX_W-1:0]     payload_byte;
    logic [cfp_pkg::CMD_W-1:0]    command_id;
    logic [cfp_pkg::LEN_W-1:0]    payload_length;
    logic [cfp_pkg::SEQ_W-1:0]    sequence_number;
    logic                         link_out;

    modport source (output valid, output result_kind, output payload_byte,
                    output command_id, output payload_length, output sequence_number,
                    output link_out, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input command_id, input payload_length, input sequence_number,
                    input link_out, output ready);
endinterface

`default_nettype wire

### design/cfp_crc_byte.sv
`default_nettype none

// reflected crc advanced by one byte, lsb first
module cfp_crc_byte #(
    parameter int W = cfp_pkg::CRC16_W
) (
    input  wire logic [W-1:0]             i_crc,
    input  wire logic [W-1:0]             i_poly,
    input  wire logic [cfp_pkg::RX_W-1:0] i_byte,
    output logic      [W-1:0]             o_crc
);

    logic [W-1:0] v;

    always_comb begin
        v = i_crc ^ W'(i_byte);
        for (int k = 0; k < cfp_pkg::RX_W; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ i_poly;
            end else begin
                v = v >> 1;
            end
        end
        o_crc = v;
    end

endmodule

`default_nettype wire

### design/cfp_cfg_regs.sv
`default_nettype none

module cfp_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cfp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cfp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cfp_pkg::t_cfg                        o_cfg
);

    cfp_pkg::t_cfg r_cfg;
    cfp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfp_pkg::CFG_START_BYTE: n_cfg.start_byte = i_cfg_data[cfp_pkg::RX_W-1:0];
                cfp_pkg::CFG_MAX_LEN:    n_cfg.max_len    = i_cfg_data[cfp_pkg::LEN_W-1:0];
                cfp_pkg::CFG_CRC8_POLY:  n_cfg.crc8_poly  = i_cfg_data[cfp_pkg::CRC8_W-1:0];
                cfp_pkg::CFG_CRC8_INIT:  n_cfg.crc8_init  = i_cfg_data[cfp_pkg::CRC8_W-1:0];
                cfp_pkg::CFG_CRC16_POLY: n_cfg.crc16_poly = i_cfg_data[cfp_pkg::CRC16_W-1:0];
                cfp_pkg::CFG_CRC16_INIT: n_cfg.crc16_init = i_cfg_data[cfp_pkg::CRC16_W-1:0];
                default:                 n_cfg = r_cfg;  // unused indices ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= cfp_pkg::RST_START_BYTE;
            r_cfg.max_len    <= cfp_pkg::RST_MAX_LEN;
            r_cfg.crc8_poly  <= cfp_pkg::RST_CRC8_POLY;
            r_cfg.crc8_init  <= cfp_pkg::RST_CRC8_INIT;
            r_cfg.crc16_poly <= cfp_pkg::RST_CRC16_POLY;
            r_cfg.crc16_init <= cfp_pkg::RST_CRC16_INIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/cfp_parser.sv
`default_nettype none

module cfp_parser #(
    parameter int FRAME_MAX_BYTES = cfp_pkg::FRAME_MAX_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cfp_pkg::t_cfg              i_cfg,
    input  wire logic                       i_accept,
    input  wire logic [cfp_pkg::RX_W-1:0]   i_byte,
    input  wire logic                       i_link,
    output logic                            o_emit,
    output cfp_pkg::t_result                o_result
);

    localparam int LEN_W   = cfp_pkg::LEN_W;
    localparam int LEN_CAP = FRAME_MAX_BYTES - cfp_pkg::FRAME_OVERHEAD;
    // payload position counts up to the length plus one (waiting for crc high byte)
    localparam int POS_W   = $clog2(LEN_CAP + 2);
    localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

    cfp_pkg::t_parse_step r_state, n_state;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [LEN_W-1:0]             r_len, n_len;
    logic [cfp_pkg::SEQ_W-1:0]    r_seq, n_seq;
    logic [cfp_pkg::CRC8_W-1:0]   r_hcrc, n_hcrc;
    logic [cfp_pkg::CRC16_W-1:0]  r_fcrc, n_fcrc;
    logic [cfp_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [cfp_pkg::RX_W-1:0]     r_crc_lo, n_crc_lo;

    logic [cfp_pkg::CRC8_W-1:0]   hcrc_base, hcrc_next;
    logic [cfp_pkg::CRC16_W-1:0]  fcrc_base, fcrc_next;
    logic                         is_start;
    logic [LEN_W-1:0]             len_full;
    logic                         len_ok;
    logic                         hcrc_ok;
    logic                         in_payload;
    logic                         at_crc_lo;
    logic                         frame_ok;

    // inits are taken on the start byte itself
    assign is_start  = (i_byte == i_cfg.start_byte);
    assign hcrc_base = (r_state == cfp_pkg::ST_HUNT) ? i_cfg.crc8_init : r_hcrc;
    assign fcrc_base = (r_state == cfp_pkg::ST_HUNT) ? i_cfg.crc16_init : r_fcrc;

    cfp_crc_byte #(.W(cfp_pkg::CRC8_W)) u_crc8 (
        .i_crc  (hcrc_base),
        .i_poly (i_cfg.crc8_poly),
        .i_byte (i_byte),
        .o_crc  (hcrc_next)
    );

    cfp_crc_byte #(.W(cfp_pkg::CRC16_W)) u_crc16 (
        .i_crc  (fcrc_base),
        .i_poly (i_cfg.crc16_poly),
        .i_byte (i_byte),
        .o_crc  (fcrc_next)
    );

    // high length byte must keep the 16-bit length under 1024
    assign len_full   = {i_byte[1:0], r_len[7:0]};
    assign len_ok     = (i_byte[7:2] == '0) && (len_full <= i_cfg.max_len)
                        && (len_full <= LEN_CAP_V);
    assign hcrc_ok    = (r_hcrc == i_byte);
    assign in_payload = (LEN_W'(r_pos) < r_len);
    assign at_crc_lo  = (LEN_W'(r_pos) == r_len);
    assign frame_ok   = ({i_byte, r_crc_lo} == r_fcrc);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfp_pkg::ST_HUNT:   if (is_start) n_state = cfp_pkg::ST_LEN_LO;
            cfp_pkg::ST_LEN_LO: n_state = cfp_pkg::ST_LEN_HI;
            cfp_pkg::ST_LEN_HI: n_state = len_ok ? cfp_pkg::ST_SEQ : cfp_pkg::ST_HUNT;
            cfp_pkg::ST_SEQ:    n_state = cfp_pkg::ST_HCRC;
            cfp_pkg::ST_HCRC:   n_state = hcrc_ok ? cfp_pkg::ST_CMD_LO : cfp_pkg::ST_HUNT;
            cfp_pkg::ST_CMD_LO: n_state = cfp_pkg::ST_CMD_HI;
            cfp_pkg::ST_CMD_HI: n_state = cfp_pkg::ST_BODY;
            cfp_pkg::ST_BODY:   if (!in_payload && !at_crc_lo) n_state = cfp_pkg::ST_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        n_pos    = '0;
        n_len    = r_len;
        n_seq    = r_seq;
        n_hcrc   = r_hcrc;
        n_fcrc   = r_fcrc;
        n_cmd    = r_cmd;
        n_crc_lo = r_crc_lo;
        o_emit   = 1'b0;

        o_result.kind            = cfp_pkg::KIND_PAYLOAD;
        o_result.payload_byte    = '0;
        o_result.command_id      = r_cmd;
        o_result.payload_length  = r_len;
        o_result.sequence_number = r_seq;
        o_result.link            = i_link;

        unique case (r_state)
            cfp_pkg::ST_HUNT: begin
                if (is_start) begin
                    n_hcrc = hcrc_next;
                    n_fcrc = fcrc_next;
                end
            end
            cfp_pkg::ST_LEN_LO: begin
                n_len  = LEN_W'(i_byte);
                n_hcrc = hcrc_next;
                n_fcrc = fcrc_next;
            end
            cfp_pkg::ST_LEN_HI: begin
                n_len  = len_full;
                n_hcrc = hcrc_next;
                n_fcrc = fcrc_next;
            end
            cfp_pkg::ST_SEQ: begin
                n_seq  = i_byte;
                n_hcrc = hcrc_next;
                n_fcrc = fcrc_next;
            end
            cfp_pkg::ST_HCRC: begin
                n_fcrc = fcrc_next;
            end
            cfp_pkg::ST_CMD_LO: begin
                n_cmd  = {r_cmd[15:8], i_byte};
                n_fcrc = fcrc_next;
            end
            cfp_pkg::ST_CMD_HI: begin
                n_cmd  = {i_byte, r_cmd[7:0]};
                n_fcrc = fcrc_next;
            end
            cfp_pkg::ST_BODY: begin
                if (in_payload) begin
                    n_fcrc                = fcrc_next;
                    n_pos                 = r_pos + 1'b1;
                    o_emit                = 1'b1;
                    o_result.payload_byte = i_byte;
                end else if (at_crc_lo) begin
                    n_crc_lo = i_byte;
                    n_pos    = r_pos + 1'b1;
                end else begin
                    o_emit        = 1'b1;
                    o_result.kind = frame_ok ? cfp_pkg::KIND_ACCEPT : cfp_pkg::KIND_REJECT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfp_pkg::ST_HUNT;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_len    <= n_len;
            r_seq    <= n_seq;
            r_hcrc   <= n_hcrc;
            r_fcrc   <= n_fcrc;
            r_cmd    <= n_cmd;
            r_crc_lo <= n_crc_lo;
        end
    end

    // the frame verdict always returns the parser to the hunt
    a_verdict_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_emit && o_result.kind != cfp_pkg::KIND_PAYLOAD)
        |=> (r_state == cfp_pkg::ST_HUNT))
        else $error("frame verdict did not restart the hunt");

    // results only come out of the payload phase
    a_emit_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_state == cfp_pkg::ST_BODY))
        else $error("result outside payload phase");

    // position never runs past the crc high byte slot
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfp_pkg::ST_BODY)
        |-> ((LEN_W + 1)'(r_pos) <= ({1'b0, r_len} + 1'b1)))
        else $error("payload position beyond frame length");

    // an accepted length respects the build limit
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfp_pkg::ST_SEQ) |-> (r_len <= LEN_CAP_V))
        else $error("accepted length above frame limit");

endmodule

`default_nettype wire

### design/cfp_out_reg.sv
`default_nettype none

// result register; frees itself when the sink takes the word
module cfp_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_emit,
    input  wire cfp_pkg::t_result i_result,
    output logic               o_can_take,
    cfp_res_if.source          o_res
);

    logic             r_valid;
    cfp_pkg::t_result r_res;

    assign o_can_take = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= i_emit;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_emit) begin
            r_res <= i_result;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.result_kind     = r_res.kind;
    assign o_res.payload_byte    = r_res.payload_byte;
    assign o_res.command_id      = r_res.command_id;
    assign o_res.payload_length  = r_res.payload_length;
    assign o_res.sequence_number = r_res.sequence_number;
    assign o_res.link_out        = r_res.link;

endmodule

`default_nettype wire

### design/crc_checked_frame_parser_unit.sv
`default_nettype none

// channel   dir  fields                                              notes
// i_rx      in   rx_byte, source_link                                one word per received byte
// o_res     out  result_kind, payload_byte, command_id,
//                payload_length, sequence_number, link_out           zero or one word per byte
// i_cfg_*   in   i_cfg_we, i_cfg_idx, i_cfg_data                     register write, no read-back
//
// one byte is taken per cycle while i_rx.ready is high; its result appears in the result register in the next cycle
// the whole step (state decode plus byte-wide crc-8 and crc-16 update) is combinational logic
// i_rx.ready drops only while the result register holds a word the sink has not yet taken
// reset (synchronous, active low) puts the parser in the hunt and the registers at defaults
// no clearing pass: the block is ready as soon as reset is released
module crc_checked_frame_parser_unit #(
    parameter int FRAME_MAX_BYTES = cfp_pkg::FRAME_MAX_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cfp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cfp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    cfp_rx_if.sink                               i_rx,
    cfp_res_if.source                            o_res
);

    cfp_pkg::t_cfg    cfg;
    cfp_pkg::t_result result;
    logic             emit;
    logic             can_take;
    logic             accept;

    // a byte is taken whenever the result register is free or draining
    assign i_rx.ready = can_take;
    assign accept     = i_rx.valid && can_take;

    cfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // frame state machine with both crc units
    cfp_parser #(.FRAME_MAX_BYTES(FRAME_MAX_BYTES)) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_byte   (i_rx.rx_byte),
        .i_link   (i_rx.source_link),
        .o_emit   (emit),
        .o_result (result)
    );

    // output register between parser and sink
    cfp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_emit     (emit),
        .i_result   (result),
        .o_can_take (can_take),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire
